/* rtl/core/assert_macros.svh */
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property checked at each rising edge outside reset
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define CHK_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* rtl/core/schist_pkg.sv */
package schist_pkg;

	localparam int ENTRIES = 256;
	localparam int IDX_W   = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
	localparam int USED_W  = $clog2(ENTRIES + 1);

	localparam logic [2:0] MODE_CLEAR    = 3'd0;
	localparam logic [2:0] MODE_ADD      = 3'd1;
	localparam logic [2:0] MODE_SET      = 3'd2;
	localparam logic [2:0] MODE_APPEND   = 3'd3;
	localparam logic [2:0] MODE_ZERO     = 3'd4;
	localparam logic [2:0] MODE_SORT_CAT = 3'd5;
	localparam logic [2:0] MODE_SORT_CNT = 3'd6;
	localparam logic [2:0] MODE_READ     = 3'd7;

	localparam logic [1:0] ST_UPDATED  = 2'd0;
	localparam logic [1:0] ST_APPENDED = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_DONE     = 2'd3;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] category;
		logic signed [63:0] amount;
		logic [7:0]         entry_index;
	} item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_category;
		logic signed [63:0] read_count;
		logic [8:0]         entries_used;
	} result_t;

	typedef struct packed {
		logic signed [31:0] cat;
		logic signed [63:0] cnt;
	} entry_t;

	// broadcast to every cell
	typedef struct packed {
		logic               by_count;
		logic               do_add;
		logic               zero;
		logic signed [31:0] key;
		entry_t             new_entry;
	} cell_ctl_t;

	// per-cell selects
	typedef struct packed {
		logic valid;
		logic rd_sel;
		logic append;
		logic update;
		logic merge;
		logic take_right;
		logic take_left;
	} cell_sel_t;

	typedef struct packed {
		logic match;
		logic after;
		logic dup;
	} cell_stat_t;

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			sat_add = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
		end else begin
			sat_add = s;
		end
	endfunction

endpackage

/* rtl/core/schist_cell.sv */
module schist_cell (
	input  logic                    clk,
	input  schist_pkg::cell_ctl_t   ctl,
	input  schist_pkg::cell_sel_t   sel,
	input  schist_pkg::entry_t      left,
	input  schist_pkg::entry_t      right,
	input  logic                    right_valid,
	output schist_pkg::entry_t      data,
	output schist_pkg::cell_stat_t  stat,
	output schist_pkg::entry_t      rd
);

	schist_pkg::entry_t data_q;
	schist_pkg::entry_t rd_q;
	logic               match_q;
	logic signed [63:0] addend;
	logic signed [63:0] sum;

	assign addend = sel.merge ? right.cnt : ctl.new_entry.cnt;
	assign sum    = schist_pkg::sat_add(data_q.cnt, addend);

	always_ff @(posedge clk) begin
		if (sel.append) begin
			data_q <= ctl.new_entry;
		end else if (sel.update) begin
			data_q.cnt <= ctl.do_add ? sum : ctl.new_entry.cnt;
		end else if (sel.merge) begin
			data_q.cnt <= sum;
		end else if (ctl.zero) begin
			data_q.cnt <= '0;
		end else if (sel.take_right) begin
			data_q <= right;
		end else if (sel.take_left) begin
			data_q <= left;
		end
		// sampled every cycle, used in the cycle after the beat is taken
		match_q <= sel.valid && (data_q.cat == ctl.key);
		rd_q    <= sel.rd_sel ? data_q : '0;
	end

	always_comb begin
		stat.match = match_q;
		stat.dup   = sel.valid && right_valid && (data_q.cat == right.cat);
		if (!(sel.valid && right_valid)) begin
			stat.after = 1'b0;
		end else if (ctl.by_count && (data_q.cnt != right.cnt)) begin
			stat.after = $signed(data_q.cnt) > $signed(right.cnt);
		end else begin
			stat.after = $signed(data_q.cat) > $signed(right.cat);
		end
	end

	assign data = data_q;
	assign rd   = rd_q;

endmodule

/* rtl/core/sparse_category_histogram_table_unit.sv */
// add, set, append, clear, zero counts and read run in the execute state and register their
// result into the output register; sort by count runs one odd-even pass per cycle, sort by
// category does the same and then folds one duplicate pair per cycle until none is left
// flow: one item at a time; next beat taken once the output register holds no stalled result
// reset: arst_n clears the fill count, the sequencer and the output valid; cell contents are
// not cleared and only entries below the fill count are ever looked at
module sparse_category_histogram_table_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  schist_pkg::item_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output schist_pkg::result_t result
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_SORT  = 2'd2;
	localparam logic [1:0] S_MERGE = 2'd3;

	localparam int N = schist_pkg::ENTRIES;

	logic [1:0]                      state_q, state_d;
	logic [schist_pkg::USED_W-1:0]   used_q, used_d;
	logic [schist_pkg::IDX_W-1:0]    pass_q, pass_d;
	logic                            res_v_q;
	schist_pkg::result_t             res_q;
	logic [2:0]                      mode_q;
	logic signed [31:0]              cat_q;
	logic signed [63:0]              amt_q;

	logic                            accept;
	logic                            emit;
	logic [1:0]                      emit_status;
	logic                            exec;
	logic                            is_addset;
	logic                            any_match;
	logic                            any_dup;
	logic                            do_append;

	schist_pkg::cell_ctl_t           ctl;
	schist_pkg::entry_t              cell_data [N];
	schist_pkg::entry_t              cell_rd   [N];
	schist_pkg::cell_stat_t          stat      [N];
	schist_pkg::cell_sel_t           sel       [N];
	logic [N-1:0]                    match_v, dup_v, after_v, swap_v;
	logic [N-1:0]                    first_m, first_d, above_d;
	logic [95:0]                     rd_or;
	schist_pkg::entry_t              rd_entry;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE) || (res_v_q && result_stall);
	assign exec       = (state_q == S_EXEC);
	assign is_addset  = (mode_q == schist_pkg::MODE_ADD) || (mode_q == schist_pkg::MODE_SET);
	assign any_match  = |match_v;
	assign any_dup    = |dup_v;
	assign do_append  = exec && ((mode_q == schist_pkg::MODE_APPEND) || (is_addset && !any_match));

	// lowest set bit picks the first match and the first duplicate pair
	assign first_m = match_v & (~match_v + N'(1));
	assign first_d = dup_v & (~dup_v + N'(1));
	assign above_d = ~(first_d | (first_d - N'(1)));

	assign ctl.by_count  = (mode_q == schist_pkg::MODE_SORT_CNT);
	assign ctl.do_add    = (mode_q == schist_pkg::MODE_ADD);
	assign ctl.zero      = exec && (mode_q == schist_pkg::MODE_ZERO);
	assign ctl.key       = item.category;
	assign ctl.new_entry = '{cat: cat_q, cnt: amt_q};

	for (genvar i = 0; i < N; i++) begin : g_cell
		assign match_v[i] = stat[i].match;
		assign dup_v[i]   = stat[i].dup;
		assign after_v[i] = stat[i].after;
		assign swap_v[i]  = after_v[i] && ((i % 2) == int'(pass_q[0]));

		assign sel[i].valid      = (schist_pkg::USED_W'(i) < used_q);
		assign sel[i].rd_sel     = sel[i].valid && (32'(item.entry_index) == i);
		assign sel[i].append     = do_append && (schist_pkg::USED_W'(i) == used_q);
		assign sel[i].update     = exec && is_addset && first_m[i];
		assign sel[i].merge      = (state_q == S_MERGE) && first_d[i];
		assign sel[i].take_right = ((state_q == S_SORT) && swap_v[i])
			|| ((state_q == S_MERGE) && above_d[i]);

		if (i == 0) begin : g_first
			assign sel[i].take_left = 1'b0;
		end else begin : g_mid
			assign sel[i].take_left = (state_q == S_SORT) && swap_v[i-1];
		end

		if (i == N - 1) begin : g_last
			schist_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.sel         (sel[i]),
				.left        (cell_data[i-1]),
				.right       ('0),
				.right_valid (1'b0),
				.data        (cell_data[i]),
				.stat        (stat[i]),
				.rd          (cell_rd[i])
			);
		end else if (i == 0) begin : g_head
			schist_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.sel         (sel[i]),
				.left        ('0),
				.right       (cell_data[i+1]),
				.right_valid (sel[i+1].valid),
				.data        (cell_data[i]),
				.stat        (stat[i]),
				.rd          (cell_rd[i])
			);
		end else begin : g_body
			schist_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.sel         (sel[i]),
				.left        (cell_data[i-1]),
				.right       (cell_data[i+1]),
				.right_valid (sel[i+1].valid),
				.data        (cell_data[i]),
				.stat        (stat[i]),
				.rd          (cell_rd[i])
			);
		end
	end

	// at most one cell holds a nonzero read value
	always_comb begin
		rd_or = '0;
		for (int k = 0; k < N; k++) begin
			rd_or = rd_or | cell_rd[k];
		end
	end
	assign rd_entry = schist_pkg::entry_t'(rd_or);

	always_comb begin
		state_d     = state_q;
		used_d      = used_q;
		pass_d      = pass_q;
		emit        = 1'b0;
		emit_status = schist_pkg::ST_DONE;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				emit    = 1'b1;
				case (mode_q)
					schist_pkg::MODE_CLEAR: begin
						used_d = '0;
					end
					schist_pkg::MODE_ADD, schist_pkg::MODE_SET, schist_pkg::MODE_APPEND: begin
						if (is_addset && any_match) begin
							emit_status = schist_pkg::ST_UPDATED;
						end else if (used_q < schist_pkg::USED_W'(N)) begin
							used_d      = used_q + 1'b1;
							emit_status = schist_pkg::ST_APPENDED;
						end else begin
							emit_status = schist_pkg::ST_FULL;
						end
					end
					schist_pkg::MODE_SORT_CAT, schist_pkg::MODE_SORT_CNT: begin
						emit    = 1'b0;
						pass_d  = '0;
						state_d = S_SORT;
					end
					default: begin
					end
				endcase
			end
			S_SORT: begin
				pass_d = pass_q + 1'b1;
				if (pass_q == schist_pkg::IDX_W'(N - 1)) begin
					if (mode_q == schist_pkg::MODE_SORT_CAT) begin
						state_d = S_MERGE;
					end else begin
						state_d = S_IDLE;
						emit    = 1'b1;
					end
				end
			end
			S_MERGE: begin
				if (any_dup) begin
					used_d = used_q - 1'b1;
				end else begin
					state_d = S_IDLE;
					emit    = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			pass_q  <= '0;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			pass_q  <= pass_d;
			if (emit) begin
				res_v_q <= 1'b1;
			end else if (!result_stall) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= item.mode;
			cat_q  <= item.category;
			amt_q  <= item.amount;
		end
		if (emit) begin
			res_q.status       <= emit_status;
			res_q.entries_used <= 9'(used_d);
			if (mode_q == schist_pkg::MODE_READ) begin
				res_q.read_category <= rd_entry.cat;
				res_q.read_count    <= rd_entry.cnt;
			end else begin
				res_q.read_category <= '0;
				res_q.read_count    <= '0;
			end
		end
	end

	assign result_valid = res_v_q;
	assign result       = res_q;

endmodule

/* rtl/core/schist_checker.sv */
`include "assert_macros.svh"

module schist_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_stall,
	input logic                result_valid,
	input logic                result_stall,
	input schist_pkg::result_t result
);

	`CHK_ASSERT(a_res_hold, clk, arst_n, result_valid && result_stall |=> result_valid, "result beat dropped while stalled")
	`CHK_NEVER(a_no_overlap, clk, arst_n, item_valid && !item_stall && result_valid && result_stall, "beat taken while a result is pending")
	`CHK_ASSERT(a_full_count, clk, arst_n, result_valid && result.status == schist_pkg::ST_FULL |-> result.entries_used == 9'(schist_pkg::ENTRIES), "full reported on a table with room")
	`CHK_ASSERT(a_append_count, clk, arst_n, result_valid && result.status == schist_pkg::ST_APPENDED |-> result.entries_used != 9'd0, "append left the table empty")

endmodule

bind sparse_category_histogram_table_unit schist_checker u_schist_checker (.*);

/* test/tb_top.sv */
module tb_top;
	import schist_pkg::*;

	localparam int TBL_SIZE = 256;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;

	sparse_category_histogram_table_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// shadow copy of the table
	logic signed [31:0] tbl_cat [TBL_SIZE];
	logic signed [63:0] tbl_cnt [TBL_SIZE];
	int tbl_used;

	result_t expected_results[$];
	int error_count = 0;
	int idle_cycles = 0;
	bit send_gaps;
	bit recv_gaps;
	bit hold_recv;

	initial clk = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic signed [63:0] sum_clamped(logic signed [63:0] a,
		logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > 65'sh0_7fff_ffff_ffff_ffff) begin
			return 64'sh7fff_ffff_ffff_ffff;
		end
		if (s < -65'sh0_8000_0000_0000_0000) begin
			return 64'sh8000_0000_0000_0000;
		end
		return s[63:0];
	endfunction

	function automatic bit goes_later(logic signed [31:0] cx, logic signed [63:0] nx,
		logic signed [31:0] cy, logic signed [63:0] ny, bit by_count);
		if (by_count && nx != ny) begin
			return nx > ny;
		end
		return cx > cy;
	endfunction

	function automatic void sort_table(bit by_count);
		logic signed [31:0] c;
		logic signed [63:0] n;
		int j;
		for (int i = 1; i < tbl_used; i++) begin
			c = tbl_cat[i];
			n = tbl_cnt[i];
			j = i;
			while (j > 0 && goes_later(tbl_cat[j-1], tbl_cnt[j-1], c, n, by_count)) begin
				tbl_cat[j] = tbl_cat[j-1];
				tbl_cnt[j] = tbl_cnt[j-1];
				j--;
			end
			tbl_cat[j] = c;
			tbl_cnt[j] = n;
		end
	endfunction

	function automatic logic [1:0] append_bin(logic signed [31:0] c, logic signed [63:0] n);
		if (tbl_used >= TBL_SIZE) begin
			return ST_FULL;
		end
		tbl_cat[tbl_used] = c;
		tbl_cnt[tbl_used] = n;
		tbl_used++;
		return ST_APPENDED;
	endfunction

	function automatic result_t predict_histogram(item_t it);
		result_t r;
		int hit;
		int a;
		r = '0;
		r.status = ST_DONE;
		case (it.mode)
			MODE_CLEAR: tbl_used = 0;
			MODE_ADD, MODE_SET: begin
				hit = -1;
				for (int i = 0; i < tbl_used; i++) begin
					if (hit < 0 && tbl_cat[i] == it.category) hit = i;
				end
				if (hit >= 0) begin
					tbl_cnt[hit] = (it.mode == MODE_ADD) ?
						sum_clamped(tbl_cnt[hit], it.amount) : it.amount;
					r.status = ST_UPDATED;
				end else begin
					r.status = append_bin(it.category, it.amount);
				end
			end
			MODE_APPEND: r.status = append_bin(it.category, it.amount);
			MODE_ZERO: for (int i = 0; i < tbl_used; i++) tbl_cnt[i] = '0;
			MODE_SORT_CAT: begin
				sort_table(1'b0);
				if (tbl_used > 1) begin
					a = 0;
					for (int b = 1; b < tbl_used; b++) begin
						if (tbl_cat[a] != tbl_cat[b]) begin
							a++;
							tbl_cat[a] = tbl_cat[b];
							tbl_cnt[a] = tbl_cnt[b];
						end else begin
							tbl_cnt[a] = sum_clamped(tbl_cnt[a], tbl_cnt[b]);
						end
					end
					tbl_used = a + 1;
				end
			end
			MODE_SORT_CNT: sort_table(1'b1);
			default: begin
				if (it.entry_index < tbl_used) begin
					r.read_category = tbl_cat[it.entry_index];
					r.read_count = tbl_cnt[it.entry_index];
				end
			end
		endcase
		r.entries_used = tbl_used[8:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		error_count++;
	endtask

	// sends one beat, random idle bursts before it when enabled
	task automatic send_item(item_t it);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		expected_results.push_back(predict_histogram(it));
	endtask

	function automatic item_t make_item(logic [2:0] m, logic signed [31:0] c,
		logic signed [63:0] n, logic [7:0] idx);
		item_t it;
		it.mode = m;
		it.category = c;
		it.amount = n;
		it.entry_index = idx;
		return it;
	endfunction

	function automatic logic [7:0] valid_index();
		return (tbl_used == 0) ? 8'd0 : 8'($urandom_range(0, tbl_used - 1));
	endfunction

	function automatic logic signed [63:0] rand_amount();
		case ($urandom_range(0, 4))
			0: return {$urandom, $urandom};
			1: return 64'sh7fff_ffff_ffff_fff0 + $urandom_range(0, 15);
			2: return 64'sh8000_0000_0000_0000 + $urandom_range(0, 15);
			default: return $signed(64'($urandom_range(0, 40))) - 20;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_category();
		if ($urandom_range(0, 3) == 0) return $urandom;
		return $signed(32'($urandom_range(0, 12))) - 6;
	endfunction

	// receiver: stall bursts, forced holds, result check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected beat", 64'(result), 64'd0);
				end else begin
					result_t e;
					e = expected_results.pop_front();
					if (result.status !== e.status)
						report_mismatch("status", 64'(result.status), 64'(e.status));
					if (result.read_category !== e.read_category)
						report_mismatch("read_category", 64'(result.read_category),
							64'(e.read_category));
					if (result.read_count !== e.read_count)
						report_mismatch("read_count", result.read_count, e.read_count);
					if (result.entries_used !== e.entries_used)
						report_mismatch("entries_used", 64'(result.entries_used),
							64'(e.entries_used));
				end
			end
			if (hold_recv) begin
				result_stall <= 1'b1;
			end else if (idle_cycles > 0) begin
				idle_cycles <= idle_cycles - 1;
				result_stall <= 1'b1;
			end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
				idle_cycles <= $urandom_range(0, 12);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no accepted beat
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || hold_recv)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL sparse_category_histogram_table_unit");
			$finish;
		end
	end

	task automatic test_directed();
		send_item(make_item(MODE_READ, 0, 0, 8'd0));
		send_item(make_item(MODE_ADD, 32'sh7fff_ffff, 64'sh7fff_ffff_ffff_ffff, 0));
		send_item(make_item(MODE_ADD, 32'sh7fff_ffff, 64'sd5, 0));
		send_item(make_item(MODE_APPEND, 32'sh8000_0000, 64'sh8000_0000_0000_0000, 0));
		send_item(make_item(MODE_ADD, 32'sh8000_0000, -64'sd1, 0));
		send_item(make_item(MODE_SET, 32'sd3, 64'sd9, 0));
		send_item(make_item(MODE_SET, 32'sd3, -64'sd2, 8'hff));
		send_item(make_item(MODE_APPEND, 32'sd3, 64'sd4, 0));
		send_item(make_item(MODE_APPEND, 32'sh7fff_ffff, 64'sd1, 0));
		send_item(make_item(MODE_READ, 0, 0, 8'd3));
		send_item(make_item(MODE_READ, -1, -1, 8'd255));
		send_item(make_item(MODE_SORT_CNT, 0, 0, 0));
		for (int i = 0; i < 5; i++) send_item(make_item(MODE_READ, 0, 0, 8'(i)));
		send_item(make_item(MODE_SORT_CAT, 0, 0, 0));
		for (int i = 0; i < 4; i++) send_item(make_item(MODE_READ, 0, 0, 8'(i)));
		send_item(make_item(MODE_ZERO, 0, 0, 0));
		send_item(make_item(MODE_READ, 0, 0, 8'd1));
		send_item(make_item(MODE_CLEAR, 0, 0, 0));
	endtask

	// fill to capacity with the receiver holding off at first, then hit the full case
	task automatic test_full_table();
		hold_recv = 1'b1;
		fork
			begin
				for (int i = 0; i < TBL_SIZE; i++)
					send_item(make_item(MODE_APPEND, i % 7, $urandom_range(0, 9), 0));
			end
			begin
				repeat (300) @(posedge clk);
				hold_recv = 1'b0;
			end
		join
		send_item(make_item(MODE_APPEND, 99, 1, 0));
		send_item(make_item(MODE_ADD, 1000, 1, 0));
		send_item(make_item(MODE_SET, 3, 1, 0));
		send_item(make_item(MODE_READ, 0, 0, 8'd255));
		send_item(make_item(MODE_SORT_CNT, 0, 0, 0));
		send_item(make_item(MODE_READ, 0, 0, 8'd255));
		send_item(make_item(MODE_SORT_CAT, 0, 0, 0));
		send_item(make_item(MODE_READ, 0, 0, 8'd6));
		send_item(make_item(MODE_CLEAR, 0, 0, 0));
	endtask

	task automatic test_random(int count);
		int w;
		logic [2:0] m;
		for (int k = 0; k < count; k++) begin
			w = $urandom_range(0, 99);
			if (w < 30) m = MODE_ADD;
			else if (w < 40) m = MODE_SET;
			else if (w < 55) m = MODE_APPEND;
			else if (w < 80) m = MODE_READ;
			else if (w < 85) m = MODE_SORT_CAT;
			else if (w < 90) m = MODE_SORT_CNT;
			else if (w < 93) m = MODE_ZERO;
			else if (w < 95) m = MODE_CLEAR;
			else m = 3'($urandom_range(0, 7));
			if (m == MODE_READ && $urandom_range(0, 3) == 0)
				send_item(make_item(m, $urandom, {$urandom, $urandom}, 8'($urandom)));
			else
				send_item(make_item(m, rand_category(), rand_amount(), valid_index()));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		hold_recv = 1'b0;
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		tbl_used = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_random(1400);
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		test_random(250);
		item_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (2 * TBL_SIZE + 10) @(posedge clk);
		if (error_count == 0) begin
			$display("PASS sparse_category_histogram_table_unit");
		end else begin
			$display("FAIL sparse_category_histogram_table_unit");
		end
		$finish;
	end
endmodule
